// ===== src/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants for the first-fit block allocator
// Item layouts, table entry, cell command, status and register codes.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned MaxBlocksDefault   = 64;
  localparam int unsigned HeaderBytesDefault = 16;

  localparam int unsigned SizeW  = 24;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned LimitW = 25;
  localparam int unsigned PaddrW = 3;

  localparam logic [LimitW-1:0] LimitCap   = 25'd16777216;
  localparam logic [LimitW-1:0] LimitReset = 25'd1048576;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_NO_MEMORY = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_NULL_FREE = 3'd4
  } status_e;

  typedef enum logic {
    REG_HEAP_BASE  = 1'b0,
    REG_HEAP_LIMIT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             operation;
    logic [SizeW-1:0] request_size;
    logic [AddrW-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0] payload_address;
    logic [2:0]       status;
  } out_item_t;

  typedef struct packed {
    logic             free;
    logic [SizeW-1:0] size;
  } entry_t;

  // broadcast to every cell; indexes travel beside it
  typedef struct packed {
    logic             wr_en;
    logic             wr_free;
    logic [SizeW-1:0] wr_size;
    logic             del_en;
    logic             scan_load;
    logic             scan_shift;
  } cell_cmd_t;

endpackage

// ===== src/ffba_cell.sv =====
// ----------------------------------------------------------------------------
// ffba_cell: one table slot of the allocator
// Holds one block entry and one scan copy; closes gaps by taking its
// neighbor's entry and streams the scan copy toward slot zero.
// ----------------------------------------------------------------------------
module ffba_cell #(
  parameter int unsigned IdxW = 6,
  parameter int unsigned Idx  = 0
) (
  input  logic               clk_i,
  input  ffba_pkg::cell_cmd_t cmd_i,
  input  logic [IdxW-1:0]    wr_idx_i,
  input  logic [IdxW-1:0]    del_idx_i,
  input  ffba_pkg::entry_t   next_entry_i,
  input  ffba_pkg::entry_t   next_scan_i,
  output ffba_pkg::entry_t   entry_o,
  output ffba_pkg::entry_t   scan_o
);
  import ffba_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  entry_t entry_q, entry_d;
  entry_t scan_q, scan_d;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.del_en && (MyIdx >= del_idx_i)) begin
      entry_d = next_entry_i;
    end else if (cmd_i.wr_en && (MyIdx == wr_idx_i)) begin
      entry_d.free = cmd_i.wr_free;
      entry_d.size = cmd_i.wr_size;
    end
  end

  always_comb begin
    scan_d = scan_q;
    if (cmd_i.scan_load) begin
      scan_d = entry_q;
    end else if (cmd_i.scan_shift) begin
      scan_d = next_scan_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    scan_q  <= scan_d;
  end

  assign entry_o = entry_q;
  assign scan_o  = scan_q;

endmodule

// ===== src/first_fit_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top: first-fit heap block allocator
// Block table kept in a row of cells; a sequencer walks it per item.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | in_item_i  (in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
//   cfg     | input     | APB write/read       | heap_base, heap_limit
//
// An alloc or release item snapshots the table into the scan chain in S_LOAD,
// walks it entry by entry in S_WALK until a fit, its block or the end of the
// table, and posts the result in S_FIN once the output register is free. A
// release stops walking at its block and merges in S_NEXT and, when both
// neighbors are free, in S_DEL2. Zero-size and null requests go to S_FIN.
// Reset empties the table at once; no clearing pass. A stalled result is
// held in the output register and the next item waits behind it.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::MaxBlocksDefault,
  parameter int unsigned HEADER_BYTES = ffba_pkg::HeaderBytesDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ffba_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ffba_pkg::out_item_t             out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ffba_pkg::PaddrW-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import ffba_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CntW-1:0]  MaxCnt = CntW'(MAX_BLOCKS);
  localparam logic [AddrW-1:0] Hdr32  = AddrW'(HEADER_BYTES);
  localparam logic [SizeW-1:0] Hdr24  = SizeW'(HEADER_BYTES);
  localparam logic [LimitW:0]  Hdr26  = (LimitW + 1)'(HEADER_BYTES);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_WALK = 6'b000100,
    S_NEXT = 6'b001000,
    S_DEL2 = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [AddrW-1:0]  base_q;
  logic [LimitW-1:0] limit_q;

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   k_q, k_d;
  logic [LimitW-1:0] used_q, used_d;
  logic [AddrW-1:0]  acc_q, acc_d;
  logic              op_q, op_d;
  logic [LimitW-1:0] need_q, need_d;
  logic [AddrW-1:0]  req_addr_q, req_addr_d;
  logic              pv_free_q, pv_free_d;
  logic [SizeW-1:0]  pv_size_q, pv_size_d;
  logic [SizeW-1:0]  cur_size_q, cur_size_d;
  logic [AddrW-1:0]  res_addr_q, res_addr_d;
  logic [2:0]        res_stat_q, res_stat_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  cell_cmd_t         cmd;
  logic [IdxW-1:0]   wr_idx;
  logic [IdxW-1:0]   del_idx;

  entry_t entry_w [MAX_BLOCKS];
  entry_t scan_w  [MAX_BLOCKS];
  entry_t head;

  logic              cfg_wr;
  logic [LimitW-1:0] lim;
  logic [LimitW:0]   total;
  logic              no_room;
  logic              nx_free;
  logic [SizeW-1:0]  new_size;
  logic [CntW-1:0]   k_inc;

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    entry_t nx_e, nx_s;
    if (i == MAX_BLOCKS - 1) begin : g_last
      assign nx_e = '0;
      assign nx_s = '0;
    end else begin : g_mid
      assign nx_e = entry_w[i+1];
      assign nx_s = scan_w[i+1];
    end
    ffba_cell #(
      .IdxW (IdxW),
      .Idx  (i)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .wr_idx_i     (wr_idx),
      .del_idx_i    (del_idx),
      .next_entry_i (nx_e),
      .next_scan_i  (nx_s),
      .entry_o      (entry_w[i]),
      .scan_o       (scan_w[i])
    );
  end

  assign head = scan_w[0];

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (cfg_reg_e'(paddr[2]))
      REG_HEAP_BASE:  prdata = base_q;
      REG_HEAP_LIMIT: prdata = {{(32 - LimitW){1'b0}}, limit_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      limit_q <= LimitReset;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[2]))
        REG_HEAP_BASE:  base_q  <= pwdata;
        REG_HEAP_LIMIT: limit_q <= pwdata[LimitW-1:0];
        default:        base_q  <= base_q;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign lim     = (limit_q > LimitCap) ? LimitCap : limit_q;
  assign total   = {1'b0, need_q} + Hdr26;
  assign no_room = (cnt_q >= MaxCnt) || (used_q > lim)
                || (total > ({1'b0, lim} - {1'b0, used_q}));
  assign k_inc   = k_q + CntW'(1);
  assign nx_free = (k_inc < cnt_q) && head.free;
  assign new_size = nx_free ? (cur_size_q + Hdr24 + head.size) : cur_size_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    used_d      = used_q;
    acc_d       = acc_q;
    op_d        = op_q;
    need_d      = need_q;
    req_addr_d  = req_addr_q;
    pv_free_d   = pv_free_q;
    pv_size_d   = pv_size_q;
    cur_size_d  = cur_size_q;
    res_addr_d  = res_addr_q;
    res_stat_d  = res_stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cmd         = '0;
    wr_idx      = k_q[IdxW-1:0];
    del_idx     = k_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = in_item_i.operation;
          need_d     = ({1'b0, in_item_i.request_size} + LimitW'(7)) & ~LimitW'(7);
          req_addr_d = in_item_i.block_address;
          res_addr_d = '0;
          res_stat_d = ST_OK;
          if (op_e'(in_item_i.operation) == OP_ALLOC) begin
            if (in_item_i.request_size == '0) begin
              res_stat_d = ST_ZERO_SIZE;
              state_d    = S_FIN;
            end else begin
              state_d = S_LOAD;
            end
          end else begin
            if (in_item_i.block_address == '0) begin
              res_stat_d = ST_NULL_FREE;
              state_d    = S_FIN;
            end else begin
              state_d = S_LOAD;
            end
          end
        end
      end

      S_LOAD: begin
        cmd.scan_load = 1'b1;
        k_d           = '0;
        acc_d         = base_q + Hdr32;
        pv_free_d     = 1'b0;
        state_d       = S_WALK;
      end

      S_WALK: begin
        if (k_q == cnt_q) begin
          // walked off the end
          if (op_e'(op_q) == OP_ALLOC) begin
            if (no_room) begin
              res_stat_d = ST_NO_MEMORY;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_free = 1'b0;
              cmd.wr_size = need_q[SizeW-1:0];
              wr_idx      = cnt_q[IdxW-1:0];
              cnt_d       = cnt_q + CntW'(1);
              used_d      = used_q + total[LimitW-1:0];
              res_addr_d  = acc_q;
            end
          end else begin
            res_stat_d = ST_UNKNOWN;
          end
          state_d = S_FIN;
        end else if ((op_e'(op_q) == OP_ALLOC) && head.free
                     && ({1'b0, head.size} >= need_q)) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_free = 1'b0;
          cmd.wr_size = head.size;
          res_addr_d  = acc_q;
          state_d     = S_FIN;
        end else if ((op_e'(op_q) == OP_RELEASE) && (acc_q == req_addr_q)) begin
          // found; next cycle shows the right neighbor
          cur_size_d     = head.size;
          cmd.scan_shift = 1'b1;
          state_d        = S_NEXT;
        end else begin
          pv_free_d      = head.free;
          pv_size_d      = head.size;
          acc_d          = acc_q + Hdr32 + {{(AddrW - SizeW){1'b0}}, head.size};
          k_d            = k_inc;
          cmd.scan_shift = 1'b1;
        end
      end

      S_NEXT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_free = 1'b1;
        if (pv_free_q) begin
          // fold into the left neighbor and drop this slot
          cmd.wr_size = pv_size_q + Hdr24 + new_size;
          wr_idx      = k_q[IdxW-1:0] - IdxW'(1);
          cmd.del_en  = 1'b1;
          del_idx     = k_q[IdxW-1:0];
          cnt_d       = cnt_q - CntW'(1);
          state_d     = nx_free ? S_DEL2 : S_FIN;
        end else begin
          cmd.wr_size = new_size;
          cmd.del_en  = nx_free;
          del_idx     = k_inc[IdxW-1:0];
          if (nx_free) begin
            cnt_d = cnt_q - CntW'(1);
          end
          state_d = S_FIN;
        end
      end

      S_DEL2: begin
        cmd.del_en = 1'b1;
        del_idx    = k_q[IdxW-1:0];
        cnt_d      = cnt_q - CntW'(1);
        state_d    = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_d.payload_address = res_addr_q;
          out_d.status          = res_stat_q;
          state_d               = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    acc_q      <= acc_d;
    op_q       <= op_d;
    need_q     <= need_d;
    req_addr_q <= req_addr_d;
    pv_free_q  <= pv_free_d;
    pv_size_q  <= pv_size_d;
    cur_size_q <= cur_size_d;
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== test/ffba_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffba_checker: result checker for the first-fit block allocator
// Watches the config writes and both item channels, keeps its own block
// table and heap state, and compares each result in order.
// ----------------------------------------------------------------------------
module ffba_checker #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  ffba_pkg::in_item_t          in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  ffba_pkg::out_item_t         out_item_i,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ffba_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int                          fail_count_o,
  output int                          pending_o
);
  import ffba_pkg::*;

  logic [AddrW-1:0]  base_q;
  logic [LimitW-1:0] limit_q;
  logic [SizeW-1:0]  sizes [MAX_BLOCKS];
  logic              frees [MAX_BLOCKS];
  int unsigned       count_q;
  logic [31:0]       used_q;
  out_item_t         expected_q[$];

  assign pending_o = expected_q.size();

  function automatic void merge_runs();
    int unsigned w;
    w = 0;
    for (int unsigned r = 0; r < count_q; r++) begin
      if (w > 0 && frees[w-1] && frees[r]) begin
        sizes[w-1] = sizes[w-1] + SizeW'(HEADER_BYTES) + sizes[r];
      end else begin
        sizes[w] = sizes[r];
        frees[w] = frees[r];
        w++;
      end
    end
    count_q = w;
  endfunction

  function automatic out_item_t allocate_or_release(in_item_t it);
    out_item_t   res;
    logic [31:0] need, lim, a;
    bit          hit;
    res = '0;
    a = base_q + HEADER_BYTES;
    hit = 0;
    if (op_e'(it.operation) == OP_ALLOC) begin
      if (it.request_size == 0) begin
        res.status = ST_ZERO_SIZE;
      end else begin
        need = (32'(it.request_size) + 7) & ~32'd7;
        lim = (limit_q > LimitCap) ? 32'(LimitCap) : 32'(limit_q);
        for (int unsigned i = 0; i < count_q && !hit; i++) begin
          if (frees[i] && 32'(sizes[i]) >= need) begin
            frees[i] = 0;
            res.payload_address = a;
            hit = 1;
          end else begin
            a += HEADER_BYTES + 32'(sizes[i]);
          end
        end
        if (!hit) begin
          if (count_q >= MAX_BLOCKS || used_q > lim || need + HEADER_BYTES > lim - used_q)
          begin
            res.status = ST_NO_MEMORY;
          end else begin
            res.payload_address = a;
            sizes[count_q] = need[SizeW-1:0];
            frees[count_q] = 0;
            count_q++;
            used_q += need + HEADER_BYTES;
          end
        end
      end
    end else if (it.block_address == 0) begin
      res.status = ST_NULL_FREE;
    end else begin
      for (int unsigned i = 0; i < count_q && !hit; i++) begin
        if (a == it.block_address) begin
          frees[i] = 1;
          hit = 1;
        end else begin
          a += HEADER_BYTES + 32'(sizes[i]);
        end
      end
      if (hit) merge_runs();
      else res.status = ST_UNKNOWN;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    int        errs;
    errs = 0;
    if (!rst_ni) begin
      base_q <= '0;
      limit_q <= LimitReset;
      count_q = 0;
      used_q = 0;
      expected_q.delete();
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pwrite) begin
        if (cfg_reg_e'(paddr[2]) == REG_HEAP_BASE) base_q <= pwdata;
        else limit_q <= pwdata[LimitW-1:0];
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(allocate_or_release(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result addr=%h status=%0d", $time,
                   out_item_i.payload_address, out_item_i.status);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (want.payload_address !== out_item_i.payload_address) begin
            $display("%0t: payload_address expected %h actual %h", $time,
                     want.payload_address, out_item_i.payload_address);
            errs++;
          end
          if (want.status !== out_item_i.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_item_i.status);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

// ===== test/tb_first_fit_block_allocator_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_top: stimulus for the first-fit allocator
// Directed corner items, then random alloc/release traffic over several heap
// settings with random gaps and output stalls; the checker compares results.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_top;
  import ffba_pkg::*;

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              in_valid_i = 0;
  logic              in_stall_o;
  in_item_t          in_item_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 0;
  out_item_t         out_item_o;
  logic              psel = 0, penable = 0, pwrite = 0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count, pending;
  bit                busy_phase = 1;
  logic [31:0]       granted[$];

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  first_fit_block_allocator_top DUT (.*);

  ffba_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_item_i(out_item_o),
    .psel, .penable, .pwrite, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // remember granted addresses so releases often hit real blocks
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i && out_item_o.status == ST_OK &&
        out_item_o.payload_address != 0) granted.push_back(out_item_o.payload_address);
  end

  always @(negedge clk_i) begin
    out_stall_i <= busy_phase ? ($urandom_range(99) < 31) : 1'b0;
  end

  task automatic write_reg(cfg_reg_e r, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= PaddrW'(r) << 2; pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // returns right after the accepting edge; valid stays up until the next item
  task automatic send(logic op, logic [23:0] sz, logic [31:0] ad);
    @(negedge clk_i);
    while (busy_phase && $urandom_range(99) < 31) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_item_i <= '{operation: op, request_size: sz, block_address: ad};
    in_valid_i <= 1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic random_item();
    int k;
    logic [31:0] ad;
    k = $urandom_range(99);
    if (k < 50) begin
      send(OP_ALLOC, ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(600)), '0);
    end else if (k < 85 && granted.size() > 0) begin
      ad = granted[$urandom_range(granted.size() - 1)];
      send(OP_RELEASE, 24'($urandom), ad);
    end else begin
      ad = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
      send(OP_RELEASE, 24'($urandom), ad);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1;
    // directed: zero size, null, unknown, huge, full table, double free
    send(OP_ALLOC, 24'd0, '0);
    send(OP_RELEASE, 24'hFFFFFF, 32'd0);
    send(OP_RELEASE, '0, 32'hFFFF_FFFF);
    send(OP_ALLOC, 24'hFFFFFF, '0);
    send(OP_ALLOC, 24'd1, '0);
    send(OP_ALLOC, 24'd8, '0);
    send(OP_ALLOC, 24'd9, '0);
    send(OP_RELEASE, '0, 32'd16);
    send(OP_RELEASE, '0, 32'd16);
    send(OP_RELEASE, '0, 32'd40);
    send(OP_ALLOC, 24'd30, '0);
    send(OP_RELEASE, '0, 32'd64);
    for (int i = 0; i < 66; i++) send(OP_ALLOC, 24'd1, '0);
    drain();
    write_reg(REG_HEAP_BASE, 32'hFFFF_FF00);
    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    for (int i = 0; i < 250; i++) random_item();
    drain();
    granted.delete();
    write_reg(REG_HEAP_BASE, 32'hFFFF_FFF0);
    write_reg(REG_HEAP_LIMIT, 32'd0);
    send(OP_ALLOC, 24'd8, '0);
    drain();
    write_reg(REG_HEAP_LIMIT, 32'd200);
    for (int i = 0; i < 200; i++) random_item();
    busy_phase = 0;
    for (int i = 0; i < 150; i++) random_item();
    busy_phase = 1;
    drain();
    write_reg(REG_HEAP_BASE, $urandom & ~32'hF);
    write_reg(REG_HEAP_LIMIT, 32'd16777216);
    for (int i = 0; i < 450; i++) random_item();
    drain();
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
src/ffba_pkg.sv
src/ffba_cell.sv
src/first_fit_block_allocator_top.sv
test/ffba_checker.sv
test/tb_first_fit_block_allocator_top.sv
